// ----- src/pwsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsc_pkg
// Shared constants, types and helpers of the position-weight window scanner.
// ----------------------------------------------------------------------------
package pwsc_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int ALPHABET    = 26;
  localparam int WEIGHT_BITS = 16;
  localparam int COUNT_BITS  = 20;

  localparam int POS_BITS    = $clog2(MAX_WINDOW);
  localparam int LETTER_BITS = 5;
  localparam int LEN_BITS    = 7;
  localparam int SCORE_BITS  = 32;
  localparam int CFG_BITS    = 32;
  localparam int SUM_BITS    = WEIGHT_BITS + POS_BITS;

  // Sum tree built from groups of four.
  localparam int TREE_FAN = 4;
  localparam int TREE_L1  = MAX_WINDOW / TREE_FAN;
  localparam int TREE_L2  = TREE_L1 / TREE_FAN;

  // Input item layout.
  localparam int IN_POS_LSB    = 0;
  localparam int IN_LETTER_LSB = IN_POS_LSB + POS_BITS;
  localparam int IN_WEIGHT_LSB = IN_LETTER_LSB + LETTER_BITS;
  localparam int IN_DATA_BITS  = 32;
  localparam int IN_USER_BITS  = 3;

  // Result item layout.
  localparam int OUT_TOTAL_LSB = SCORE_BITS;
  localparam int OUT_COUNT_LSB = OUT_TOTAL_LSB + COUNT_BITS;
  localparam int OUT_DATA_BITS = 72;
  localparam int OUT_USER_BITS = 2;

  localparam logic [LETTER_BITS-1:0] LETTER_X   = LETTER_BITS'(23);
  localparam logic [LEN_BITS-1:0]    LEN_RESET  = LEN_BITS'(30);
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;

  typedef logic [LETTER_BITS-1:0]        letter_t;
  typedef logic [POS_BITS-1:0]           pos_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic [COUNT_BITS-1:0]         count_t;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_RESIDUE = 2'd1,
    REQ_READ    = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_THRESHOLD = 1'b1;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic    shift_en;    // move the letter ring by one cell
    logic    insert;      // the head cell takes new_letter instead of its neighbor
    letter_t new_letter;
    pos_t    win_last;    // cell index of the newest residue of the window
    logic    wr_en;
    pos_t    wr_pos;
    letter_t wr_letter;
    weight_t wr_weight;
    logic    inc_en;      // matched window: bump the count of each in-window cell's pair
    logic    clr;
    letter_t rd_letter;
  } cell_ctrl_t;

  function automatic logic letter_ok(input letter_t l);
    return l < LETTER_BITS'(ALPHABET);
  endfunction

  function automatic count_t count_inc(input count_t c);
    return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

// ----- src/pwsc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsc_cell
// One window position: its weight row, its count row and one letter of the
// residue ring, which it takes from its right-hand neighbor on each shift.
// ----------------------------------------------------------------------------
module pwsc_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pwsc_pkg::pos_t        idx,
  input  pwsc_pkg::cell_ctrl_t  ctrl,
  input  pwsc_pkg::letter_t     right_letter,
  output pwsc_pkg::letter_t     letter_o,
  output pwsc_pkg::weight_t     term_o,
  output pwsc_pkg::count_t      rd_count_o
);

  pwsc_pkg::letter_t letter_r;
  pwsc_pkg::letter_t letter_nxt;
  pwsc_pkg::weight_t weight_row [pwsc_pkg::ALPHABET];
  pwsc_pkg::count_t  count_row_r [pwsc_pkg::ALPHABET];
  pwsc_pkg::weight_t term_r;
  pwsc_pkg::count_t  rd_r;
  logic              head;
  logic              in_win;
  logic              own_ok;

  assign head   = (idx == ctrl.win_last);
  assign in_win = (idx <= ctrl.win_last);
  assign own_ok = pwsc_pkg::letter_ok(letter_r);

  assign letter_nxt = (ctrl.insert && head) ? ctrl.new_letter : right_letter;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letter_r <= '0;
    end else if (ctrl.shift_en) begin
      letter_r <= letter_nxt;
    end
  end

  // Weights stay undefined until software loads them.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (ctrl.wr_pos == idx) && pwsc_pkg::letter_ok(ctrl.wr_letter)) begin
      weight_row[ctrl.wr_letter] <= ctrl.wr_weight;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < pwsc_pkg::ALPHABET; j++) begin
      if (!rst_n || ctrl.clr) begin
        count_row_r[j] <= '0;
      end else if (ctrl.inc_en && in_win && (letter_r == pwsc_pkg::LETTER_BITS'(j))) begin
        count_row_r[j] <= pwsc_pkg::count_inc(count_row_r[j]);
      end
    end
  end

  // The unknown letter and codes past the alphabet add nothing.
  always_ff @(posedge clk) begin
    if (in_win && own_ok && (letter_r != pwsc_pkg::LETTER_X)) begin
      term_r <= weight_row[letter_r];
    end else begin
      term_r <= '0;
    end
    if (pwsc_pkg::letter_ok(ctrl.rd_letter)) begin
      rd_r <= count_row_r[ctrl.rd_letter];
    end else begin
      rd_r <= '0;
    end
  end

  assign letter_o   = letter_r;
  assign term_o     = term_r;
  assign rd_count_o = rd_r;

endmodule

// ----- src/pwsc_sum_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsc_sum_tree
// Registered adder tree that folds the per-cell terms into the window sum.
// ----------------------------------------------------------------------------
module pwsc_sum_tree (
  input  logic                                    clk,
  input  pwsc_pkg::weight_t                       terms [pwsc_pkg::MAX_WINDOW],
  output logic signed [pwsc_pkg::SUM_BITS-1:0]    sum_o
);

  logic signed [pwsc_pkg::SUM_BITS-1:0] l1_r   [pwsc_pkg::TREE_L1];
  logic signed [pwsc_pkg::SUM_BITS-1:0] l1_nxt [pwsc_pkg::TREE_L1];
  logic signed [pwsc_pkg::SUM_BITS-1:0] l2_r   [pwsc_pkg::TREE_L2];
  logic signed [pwsc_pkg::SUM_BITS-1:0] l2_nxt [pwsc_pkg::TREE_L2];
  logic signed [pwsc_pkg::SUM_BITS-1:0] sum_r;
  logic signed [pwsc_pkg::SUM_BITS-1:0] sum_nxt;

  always_comb begin
    for (int g = 0; g < pwsc_pkg::TREE_L1; g++) begin
      l1_nxt[g] = '0;
      for (int k = 0; k < pwsc_pkg::TREE_FAN; k++) begin
        l1_nxt[g] = l1_nxt[g] + pwsc_pkg::SUM_BITS'(terms[g*pwsc_pkg::TREE_FAN + k]);
      end
    end
    for (int g = 0; g < pwsc_pkg::TREE_L2; g++) begin
      l2_nxt[g] = '0;
      for (int k = 0; k < pwsc_pkg::TREE_FAN; k++) begin
        l2_nxt[g] = l2_nxt[g] + l1_r[g*pwsc_pkg::TREE_FAN + k];
      end
    end
    sum_nxt = '0;
    for (int g = 0; g < pwsc_pkg::TREE_L2; g++) begin
      sum_nxt = sum_nxt + l2_r[g];
    end
  end

  always_ff @(posedge clk) begin
    l1_r  <= l1_nxt;
    l2_r  <= l2_nxt;
    sum_r <= sum_nxt;
  end

  assign sum_o = sum_r;

endmodule

// ----- src/pssm_window_scan_counter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssm_window_scan_counter_core
// Scores sliding windows of streamed residues against a position-weight table
// held in a chain of 64 position cells, and counts matching windows.
// Items are taken one at a time: a new input item is accepted only after the
//   last one has passed the cell term register, the three-level sum tree and
//   its commit. A new window length realigns the letter ring one cell per
//   cycle while idle, and no item is taken until the ring is aligned.
// Reset (rst_n low, synchronous): clears window letters, fill level, counts,
//   match total and threshold, sets the length to 30; weights undefined until loaded.
// ----------------------------------------------------------------------------
module pssm_window_scan_counter_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration writes.
  input  logic                                 cfg_we,
  input  logic [pwsc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pwsc_pkg::CFG_BITS-1:0]        cfg_data,
  // Input items.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // position[5:0], letter[10:6], weight[26:11], zero fill [31:27]
  input  logic [pwsc_pkg::IN_DATA_BITS-1:0]    in_tdata,
  // req_type[1:0], first_of_sequence[2]
  input  logic [pwsc_pkg::IN_USER_BITS-1:0]    in_tuser,
  // Result items.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // window_score[31:0], match_total[51:32], count_value[71:52]
  output logic [pwsc_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  // score_valid[0], is_match[1]
  output logic [pwsc_pkg::OUT_USER_BITS-1:0]   out_tuser
);

  // The controller walks each item through the cell terms and the sum tree,
  // then commits its effects and loads the output register in the same cycle.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] stage_r;

  // Configuration registers.
  logic [pwsc_pkg::LEN_BITS-1:0]          win_len_r;
  logic signed [pwsc_pkg::SCORE_BITS-1:0] thresh_r;

  // The letter ring is aligned so that cell i holds the letter at window
  // position i for a window whose last position is align_r. A new window
  // length is reached by rotating the ring one cell per cycle while idle.
  pwsc_pkg::pos_t align_r;
  pwsc_pkg::pos_t len_m1;
  logic           aligned;

  logic [pwsc_pkg::LEN_BITS-1:0] fill_r;
  logic [pwsc_pkg::LEN_BITS-1:0] fill_base;
  logic [pwsc_pkg::LEN_BITS-1:0] fill_nxt;

  // The item in flight.
  pwsc_pkg::req_t    req_r;
  pwsc_pkg::pos_t    pos_r;
  pwsc_pkg::letter_t let_r;
  pwsc_pkg::weight_t weight_r;
  logic              full_r;

  pwsc_pkg::count_t matches_r;
  pwsc_pkg::count_t matches_nxt;
  pwsc_pkg::count_t count_sel_r;

  // Output register.
  logic                                 out_valid_r;
  logic [pwsc_pkg::OUT_DATA_BITS-1:0]   out_data_r;
  logic [pwsc_pkg::OUT_USER_BITS-1:0]   out_user_r;

  // Input item fields.
  pwsc_pkg::req_t    in_req;
  logic              in_first;
  pwsc_pkg::pos_t    in_pos;
  pwsc_pkg::letter_t in_letter;
  pwsc_pkg::weight_t in_weight;

  logic in_fire;
  logic done_fire;
  logic scored;
  logic match;

  pwsc_pkg::cell_ctrl_t ctrl;
  pwsc_pkg::letter_t    cell_letter [pwsc_pkg::MAX_WINDOW];
  pwsc_pkg::weight_t    cell_term   [pwsc_pkg::MAX_WINDOW];
  pwsc_pkg::count_t     cell_rd     [pwsc_pkg::MAX_WINDOW];

  logic signed [pwsc_pkg::SUM_BITS-1:0]   win_sum;
  logic signed [pwsc_pkg::SCORE_BITS-1:0] score_ext;

  assign in_req    = pwsc_pkg::req_t'(in_tuser[1:0]);
  assign in_first  = in_tuser[2];
  assign in_pos    = in_tdata[pwsc_pkg::IN_POS_LSB +: pwsc_pkg::POS_BITS];
  assign in_letter = in_tdata[pwsc_pkg::IN_LETTER_LSB +: pwsc_pkg::LETTER_BITS];
  assign in_weight = in_tdata[pwsc_pkg::IN_WEIGHT_LSB +: pwsc_pkg::WEIGHT_BITS];

  // A length of zero behaves as one; lengths past the chain behave as the chain.
  always_comb begin
    if (win_len_r == '0) begin
      len_m1 = '0;
    end else if (win_len_r > pwsc_pkg::LEN_BITS'(pwsc_pkg::MAX_WINDOW)) begin
      len_m1 = pwsc_pkg::POS_BITS'(pwsc_pkg::MAX_WINDOW - 1);
    end else begin
      len_m1 = pwsc_pkg::POS_BITS'(win_len_r - pwsc_pkg::LEN_BITS'(1));
    end
  end

  assign aligned   = (align_r == len_m1);
  assign in_tready = (state_r == ST_IDLE) && aligned;
  assign in_fire   = in_tvalid && in_tready;
  assign done_fire = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // The fill level restarts on the first residue of a sequence and saturates
  // at the chain length.
  assign fill_base = in_first ? '0 : fill_r;
  assign fill_nxt  = (fill_base < pwsc_pkg::LEN_BITS'(pwsc_pkg::MAX_WINDOW)) ?
                     fill_base + pwsc_pkg::LEN_BITS'(1) : fill_base;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stage_r == 2'd3) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stage_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_RUN) begin
        stage_r <= stage_r + 2'd1;
      end else begin
        stage_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= pwsc_pkg::LEN_RESET;
      thresh_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pwsc_pkg::CFG_WINDOW_LENGTH: begin
          win_len_r <= cfg_data[pwsc_pkg::LEN_BITS-1:0];
        end
        pwsc_pkg::CFG_MATCH_THRESHOLD: begin
          thresh_r <= $signed(cfg_data);
        end
        default: begin
          thresh_r <= thresh_r;
        end
      endcase
    end
  end

  // Each rotation while idle moves the alignment one position down.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= pwsc_pkg::POS_BITS'(pwsc_pkg::LEN_RESET - pwsc_pkg::LEN_BITS'(1));
    end else if ((state_r == ST_IDLE) && !aligned) begin
      align_r <= align_r - pwsc_pkg::POS_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_fire && (in_req == pwsc_pkg::REQ_RESIDUE)) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r  <= pwsc_pkg::REQ_LOAD;
      full_r <= 1'b0;
    end else if (in_fire) begin
      req_r  <= in_req;
      full_r <= (fill_nxt > {1'b0, len_m1});
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pos_r    <= in_pos;
      let_r    <= in_letter;
      weight_r <= in_weight;
    end
  end

  // Cell broadcast. A residue is written into the head cell as the ring shifts.
  always_comb begin
    ctrl            = '0;
    ctrl.shift_en   = ((state_r == ST_IDLE) && !aligned) ||
                      (in_fire && (in_req == pwsc_pkg::REQ_RESIDUE));
    ctrl.insert     = in_fire;
    ctrl.new_letter = in_letter;
    ctrl.win_last   = align_r;
    ctrl.wr_en      = done_fire && (req_r == pwsc_pkg::REQ_LOAD);
    ctrl.wr_pos     = pos_r;
    ctrl.wr_letter  = let_r;
    ctrl.wr_weight  = weight_r;
    ctrl.inc_en     = done_fire && match;
    ctrl.clr        = done_fire && (req_r == pwsc_pkg::REQ_CLEAR);
    ctrl.rd_letter  = let_r;
  end

  for (genvar g = 0; g < pwsc_pkg::MAX_WINDOW; g++) begin : g_cell
    pwsc_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .idx          (pwsc_pkg::POS_BITS'(g)),
      .ctrl         (ctrl),
      .right_letter (cell_letter[(g + 1) % pwsc_pkg::MAX_WINDOW]),
      .letter_o     (cell_letter[g]),
      .term_o       (cell_term[g]),
      .rd_count_o   (cell_rd[g])
    );
  end

  pwsc_sum_tree u_sum_tree (
    .clk   (clk),
    .terms (cell_term),
    .sum_o (win_sum)
  );

  // Count read: the cells pick the letter, here the position is picked.
  always_ff @(posedge clk) begin
    count_sel_r <= cell_rd[pos_r];
  end

  // The window sum of 64 signed 16-bit weights never leaves 22 bits, so the
  // 32-bit score is a plain sign extension.
  assign score_ext = {{(pwsc_pkg::SCORE_BITS - pwsc_pkg::SUM_BITS){win_sum[pwsc_pkg::SUM_BITS-1]}},
                      win_sum};
  assign scored    = (req_r == pwsc_pkg::REQ_RESIDUE) && full_r;
  assign match     = scored && (score_ext > thresh_r);

  always_comb begin
    if (req_r == pwsc_pkg::REQ_CLEAR) begin
      matches_nxt = '0;
    end else if (match) begin
      matches_nxt = pwsc_pkg::count_inc(matches_r);
    end else begin
      matches_nxt = matches_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matches_r <= '0;
    end else if (done_fire) begin
      matches_r <= matches_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_data_r[pwsc_pkg::SCORE_BITS-1:0] <= scored ? score_ext : '0;
      out_data_r[pwsc_pkg::OUT_TOTAL_LSB +: pwsc_pkg::COUNT_BITS] <= matches_nxt;
      out_data_r[pwsc_pkg::OUT_COUNT_LSB +: pwsc_pkg::COUNT_BITS] <=
        (req_r == pwsc_pkg::REQ_READ) ? count_sel_r : '0;
      out_user_r <= {match, scored};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the position-weight window scanner. It loads the
// weight rows of the letters that residues use, walks the request kinds and
// corner cases by hand, holds the result side off for a long stretch, then
// streams random residue sequences under several window lengths and
// thresholds. Each result item is checked field by field against a
// cycle-free model of the scanner kept here.
// ----------------------------------------------------------------------------
module testbench;
  import pwsc_pkg::*;

  localparam int     WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int     TAIL_CYCLES    = 20;    // settle time after the last result
  localparam int     LONG_HOLD      = 200;   // result side hold-off, in cycles
  localparam int     RANDOM_PHASES  = 8;
  localparam int     PHASE_ITEMS    = 48;
  localparam int     TABLE_LETTERS  = 7;     // letters whose weight rows are loaded
  localparam longint SCORE_MAX      = 64'sd2147483647;
  localparam longint SCORE_MIN      = -64'sd2147483648;
  localparam logic signed [31:0] THR_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] THR_MAX = 32'sh7FFF_FFFF;

  // One request as the sender sees it.
  typedef struct {
    req_t    req;
    pos_t    pos;
    letter_t letter;
    weight_t weight;
    logic    first;
  } scan_req_t;

  // One result item, unpacked into its fields.
  typedef struct {
    logic signed [SCORE_BITS-1:0] score;
    logic                         valid;
    logic                         match;
    count_t                       total;
    count_t                       count;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
  logic [CFG_BITS-1:0]        cfg_data = '0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [IN_DATA_BITS-1:0]    in_tdata = '0;
  logic [IN_USER_BITS-1:0]    in_tuser = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]   out_tdata;
  logic [OUT_USER_BITS-1:0]   out_tuser;

  pssm_window_scan_counter_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scanner model: its own weight table, letter history, fill level, pair
  // counts and match total, plus a copy of the two registers.
  // --------------------------------------------------------------------------
  weight_t                   pwm       [MAX_WINDOW][ALPHABET];
  count_t                    pair_hits [MAX_WINDOW][ALPHABET];
  letter_t                   recent    [MAX_WINDOW];
  int unsigned               filled = 0;
  count_t                    total_hits = '0;
  logic [LEN_BITS-1:0]       len_reg = LEN_RESET;
  logic signed [31:0]        thr_reg = '0;

  scan_result_t expected_results[$];

  // Run statistics and failure bookkeeping.
  int fail_count = 0;
  int n_items = 0;
  int n_results = 0;
  int n_scored = 0;
  int n_matches = 0;
  int n_settings = 0;

  // Stimulus shaping shared with the receiver.
  logic idle_on = 1'b1;
  int   holds_asked = 0;

  initial begin
    foreach (pwm[p, l]) begin
      pwm[p][l] = '0;
      pair_hits[p][l] = '0;
    end
    foreach (recent[k]) recent[k] = '0;
  end

  function automatic count_t bump(input count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // A length of zero scores single residues; anything past the chain uses
  // the whole chain.
  function automatic int unsigned active_span();
    if (len_reg == '0) return 1;
    if (len_reg > MAX_WINDOW) return MAX_WINDOW;
    return int'(len_reg);
  endfunction

  // Applies one accepted request to the model and returns its result item.
  function automatic scan_result_t predict_scan(input scan_req_t r);
    scan_result_t res;
    int unsigned  span;
    longint       acc;
    letter_t      c;
    res = '{score: '0, valid: 1'b0, match: 1'b0, total: '0, count: '0};
    span = active_span();
    case (r.req)
      REQ_LOAD: begin
        // Letters past the alphabet have no table row; the load is dropped.
        if (r.letter < ALPHABET) pwm[r.pos][r.letter] = r.weight;
      end
      REQ_RESIDUE: begin
        if (r.first) filled = 0;
        for (int k = MAX_WINDOW - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = r.letter;
        if (filled < MAX_WINDOW) filled++;
        if (filled >= span) begin
          // Window position 0 is the oldest residue. X and letters past the
          // alphabet add nothing to the score.
          acc = 0;
          for (int i = 0; i < span; i++) begin
            c = recent[span-1-i];
            if (c != LETTER_X && c < ALPHABET) acc += pwm[i][c];
          end
          if (acc > SCORE_MAX) acc = SCORE_MAX;
          if (acc < SCORE_MIN) acc = SCORE_MIN;
          res.valid = 1'b1;
          res.score = acc[31:0];
          n_scored++;
          if (acc > thr_reg) begin
            // X is still counted on a match; out-of-alphabet letters are not.
            res.match = 1'b1;
            n_matches++;
            total_hits = bump(total_hits);
            for (int i = 0; i < span; i++) begin
              c = recent[span-1-i];
              if (c < ALPHABET) pair_hits[i][c] = bump(pair_hits[i][c]);
            end
          end
        end
      end
      REQ_READ: begin
        if (r.letter < ALPHABET) res.count = pair_hits[r.pos][r.letter];
      end
      default: begin
        // Clear wipes counts and the total but keeps weights and the window.
        foreach (pair_hits[p, l]) pair_hits[p][l] = '0;
        total_hits = '0;
      end
    endcase
    res.total = total_hits;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. The previous item stays on the bus until either a new item
  // replaces it or a gap lowers valid, so valid never toggles within a step.
  // --------------------------------------------------------------------------
  task automatic send_item(input scan_req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, r.weight, r.letter, r.pos};
    in_tuser  <= {r.first, r.req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
    expected_results.push_back(predict_scan(r));
  endtask

  // Lowers valid and waits until every expected result item has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Writes both registers back to back; only called while the scanner is idle.
  task automatic set_config(input logic [LEN_BITS-1:0] len, input logic signed [31:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_LENGTH;
    cfg_data  <= CFG_BITS'(len);
    @(posedge clk);
    len_reg = len;
    cfg_index <= CFG_MATCH_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    thr_reg = thr;
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic scan_req_t mk_req(input req_t req, input int pos, input int letter,
                                       input int weight, input logic first);
    scan_req_t r;
    r.req    = req;
    r.pos    = pos_t'(pos);
    r.letter = letter_t'(letter);
    r.weight = weight_t'(weight);
    r.first  = first;
    return r;
  endfunction

  // Letters whose weight rows are loaded: both ends of the alphabet and the
  // run in the middle that the directed test scores.
  function automatic int table_letter(input int k);
    case (k)
      0: return 0;
      1: return 5;
      2: return 6;
      3: return 7;
      4: return 8;
      5: return 9;
      default: return ALPHABET - 1;
    endcase
  endfunction

  // Mostly loaded letters, a share of X, and some codes past the alphabet.
  function automatic int draw_letter();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return table_letter($urandom_range(0, TABLE_LETTERS - 1));
    if (pick < 87) return int'(LETTER_X);
    return $urandom_range(ALPHABET, 31);
  endfunction

  function automatic scan_req_t rand_residue(input logic first);
    return mk_req(REQ_RESIDUE, $urandom_range(0, 63), draw_letter(), $urandom(), first);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: a random wait after every result item, and on request one
  // long hold-off counted here so the scanner backs up into its input.
  // --------------------------------------------------------------------------
  int rx_wait = 0;
  int rx_draw;
  int hold_left = 0;
  int holds_served = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
      hold_left <= 0;
      holds_served <= 0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (out_tready && out_tvalid) begin
      rx_draw = idle_on ? $urandom_range(0, 4) : 0;
      out_tready <= (rx_draw == 0);
      rx_wait <= (rx_draw == 0) ? 0 : rx_draw - 1;
    end else if (!out_tready) begin
      if (rx_wait == 0) out_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result checking against the oldest expectation.
  // --------------------------------------------------------------------------
  scan_result_t want;

  function automatic void check_field(input string name, input longint exp_v,
                                      input longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result item with no request outstanding: tdata %h tuser %b",
               out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("window_score", want.score, $signed(out_tdata[31:0]));
        check_field("score_valid", want.valid, out_tuser[0]);
        check_field("is_match", want.match, out_tuser[1]);
        check_field("match_total", want.total, out_tdata[OUT_TOTAL_LSB +: COUNT_BITS]);
        check_field("count_value", want.count, out_tdata[OUT_COUNT_LSB +: COUNT_BITS]);
      end
    end
  end

  // Watchdog: any accepted item or register write restarts the count.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Loads the row of every scoring letter that residues draw, at every position,
  // before any residue is scored, so no window ever touches an unwritten
  // weight. Two corners carry the weight extremes.
  task automatic test_weight_table_load();
    int w;
    int l;
    for (int p = 0; p < MAX_WINDOW; p++) begin
      for (int k = 0; k < TABLE_LETTERS; k++) begin
        l = table_letter(k);
        w = $urandom_range(0, 65535);
        if (p == 0 && l == 0) w = 32767;
        if (p == MAX_WINDOW - 1 && l == ALPHABET - 1) w = -32768;
        send_item(mk_req(REQ_LOAD, p, l, w, 1'($urandom_range(0, 1))));
      end
    end
  endtask

  // Walks every request kind and the letter corner cases on a window of 3.
  task automatic test_directed();
    drain();
    // Lowest threshold: every scored window is a match.
    set_config(7'd3, THR_MIN);
    send_item(mk_req(REQ_LOAD, 63, 31, 7, 1'b1));          // dropped, no such letter
    send_item(mk_req(REQ_LOAD, 2, ALPHABET - 1, 32767, 1'b0));
    send_item(mk_req(REQ_LOAD, 1, 0, -32768, 1'b0));
    send_item(mk_req(REQ_RESIDUE, 0, 0, 0, 1'b1));
    send_item(mk_req(REQ_RESIDUE, 63, int'(LETTER_X), -1, 1'b0));
    send_item(mk_req(REQ_RESIDUE, 0, ALPHABET - 1, 0, 1'b0)); // first full window
    send_item(mk_req(REQ_RESIDUE, 0, 31, 0, 1'b0));         // past alphabet: adds nothing
    send_item(mk_req(REQ_RESIDUE, 0, ALPHABET, 0, 1'b0));
    send_item(mk_req(REQ_READ, 2, ALPHABET - 1, 0, 1'b0));
    send_item(mk_req(REQ_READ, 1, int'(LETTER_X), 0, 1'b0)); // X is still counted
    send_item(mk_req(REQ_READ, 0, 31, 0, 1'b1));             // answers zero
    send_item(mk_req(REQ_RESIDUE, 0, 5, 0, 1'b1));           // new sequence refills
    send_item(mk_req(REQ_RESIDUE, 0, 6, 0, 1'b0));
    send_item(mk_req(REQ_READ, 63, 0, 0, 1'b0));
    send_item(mk_req(REQ_CLEAR, 63, 31, -1, 1'b1));
    send_item(mk_req(REQ_READ, 2, ALPHABET - 1, 0, 1'b0));
    send_item(mk_req(REQ_RESIDUE, 0, 7, 0, 1'b0));
    drain();
    // Highest threshold: nothing can match.
    set_config(7'd3, THR_MAX);
    send_item(mk_req(REQ_RESIDUE, 0, 8, 0, 1'b0));
    send_item(mk_req(REQ_RESIDUE, 0, 9, 0, 1'b0));
    send_item(mk_req(REQ_READ, 0, 9, 0, 1'b0));
  endtask

  // Holds the result side off while the sender keeps pushing back to back.
  task automatic test_output_hold();
    idle_on <= 1'b0;
    holds_asked <= holds_asked + 1;
    for (int j = 0; j < 48; j++) send_item(rand_residue(j == 0));
  endtask

  // Random sequences under a series of settings. The first phases pin the
  // window length and threshold extremes; the rest mostly use short windows.
  task automatic test_random_scan();
    logic [LEN_BITS-1:0] len;
    logic signed [31:0]  thr;
    int                  sent;
    int                  seq_len;
    int                  span;
    int                  pick;
    logic                opening;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      thr = ($urandom_range(0, 7) == 0) ? $urandom() : int'($urandom_range(0, 80000)) - 40000;
      if ($urandom_range(0, 3) == 0) len = LEN_BITS'($urandom_range(0, 127));
      else len = LEN_BITS'($urandom_range(1, 12));
      case (ph)
        0: begin len = 7'd0; thr = THR_MIN; end
        1: len = 7'd127;
        2: begin len = 7'd64; thr = THR_MAX; end
        3: len = 7'd1;
        default: ;
      endcase
      drain();
      set_config(len, thr);
      idle_on <= (ph % 3 != 1);
      span = active_span();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // The opening sequence of a phase always fills the window unbroken.
        opening = (sent == 0);
        seq_len = opening ? span + $urandom_range(0, 16) : $urandom_range(1, span + 16);
        for (int j = 0; j < seq_len; j++) begin
          pick = $urandom_range(0, 99);
          if (pick < 6) begin
            pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, span - 1);
            send_item(mk_req(REQ_READ, pick, $urandom_range(0, 31), $urandom(),
                             1'($urandom_range(0, 1))));
            sent++;
          end else if (pick < 8) begin
            send_item(mk_req(REQ_LOAD, $urandom_range(0, 63), $urandom_range(0, 31),
                             $urandom(), 1'($urandom_range(0, 1))));
            sent++;
          end else if (pick < 9) begin
            send_item(mk_req(REQ_CLEAR, $urandom_range(0, 63), $urandom_range(0, 31),
                             $urandom(), 1'($urandom_range(0, 1))));
            sent++;
          end
          // A stray sequence start now and then breaks the window early.
          send_item(rand_residue(j == 0 || (!opening && $urandom_range(0, 99) < 3)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_weight_table_load();
    test_directed();
    test_output_hold();
    test_random_scan();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d result items never arrived", expected_results.size());
      fail_count++;
    end

    $display("summary: %0d requests, %0d result items, %0d register settings",
             n_items, n_results, n_settings);
    $display("summary: %0d windows scored, %0d matches, %0d failures",
             n_scored, n_matches, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pwsc_pkg.sv
src/pwsc_cell.sv
src/pwsc_sum_tree.sv
src/pssm_window_scan_counter_core.sv
verif/testbench.sv
